### design/fprq_pkg.sv
// ----------------------------------------------------------------------------
// fprq_pkg
// Shared constants and types for the FIFO page replacement queue.
// ----------------------------------------------------------------------------
package fprq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_BITS  = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD   = 2'd0,
        FN_REMOVE = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4,
        STS_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage

### design/fprq_ctrl.sv
// ----------------------------------------------------------------------------
// fprq_ctrl
// Controller: accepts a command word, then enters the execute state.
// ----------------------------------------------------------------------------
module fprq_ctrl
    import fprq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### design/fprq_datapath.sv
// ----------------------------------------------------------------------------
// fprq_datapath
// Entry row with per-entry match compare, gap-closing shift and result regs.
// ----------------------------------------------------------------------------
module fprq_datapath
    import fprq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    input  logic [FRAME_BITS-1:0] i_frame_number,
    output logic                  o_strobe,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_victim_valid,
    output logic [FRAME_BITS-1:0] o_victim_frame,
    output logic [CNT_W-1:0]      o_occupancy
);

    logic [PAGE_BITS-1:0]   r_page  [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0]  r_frame [QUEUE_DEPTH];
    logic [PAGE_BITS-1:0]   n_page  [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0]  n_frame [QUEUE_DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    t_func                  r_func;
    logic [PAGE_BITS-1:0]   r_in_page;
    logic [FRAME_BITS-1:0]  r_in_frame;
    logic [QUEUE_DEPTH-1:0] r_any_hit;
    logic [QUEUE_DEPTH-1:0] r_both_hit;
    logic [QUEUE_DEPTH-1:0] n_any_hit;
    logic [QUEUE_DEPTH-1:0] n_both_hit;
    logic [QUEUE_DEPTH-1:0] seen;
    logic                   dup;
    logic                   found;
    t_status                n_status;

    logic                   r_strobe;
    logic [STAT_W-1:0]      r_status;
    logic                   r_victim_valid;
    logic [FRAME_BITS-1:0]  r_victim_frame;

    // compare stage, against the incoming word
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_any_hit[i]  = (CNT_W'(i) < r_count) &&
                            ((r_page[i] == i_page_number) ||
                             (r_frame[i] == i_frame_number));
            n_both_hit[i] = (CNT_W'(i) < r_count) &&
                            (r_page[i] == i_page_number) &&
                            (r_frame[i] == i_frame_number);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= t_func'(i_func);
            r_in_page  <= i_page_number;
            r_in_frame <= i_frame_number;
            r_any_hit  <= n_any_hit;
            r_both_hit <= n_both_hit;
        end
    end

    // execute stage
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            seen[i] = |(r_both_hit & ~({QUEUE_DEPTH{1'b1}} << (i + 1)));
        end
        dup   = |r_any_hit;
        found = |r_both_hit;

        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            n_page[j]  = r_page[j];
            n_frame[j] = r_frame[j];
        end
        n_count  = r_count;
        n_status = STS_DUPLICATE;

        case (r_func)
            FN_LOAD: begin
                if (dup) begin
                    n_status = STS_DUPLICATE;
                end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    n_status = STS_FULL;
                end else begin
                    n_status                       = STS_INSERTED;
                    n_page[r_count[IDX_W-1:0]]     = r_in_page;
                    n_frame[r_count[IDX_W-1:0]]    = r_in_frame;
                    n_count                        = r_count + CNT_W'(1);
                end
            end
            FN_REMOVE: begin
                if (found) begin
                    n_status = STS_REMOVED;
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                        if (seen[j]) begin
                            n_page[j]  = r_page[j+1];
                            n_frame[j] = r_frame[j+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = STS_NOT_FOUND;
                end
            end
            FN_CLEAR: begin
                n_status = STS_CLEARED;
                n_count  = '0;
            end
            default: n_status = STS_DUPLICATE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
                r_page[j]  <= n_page[j];
                r_frame[j] <= n_frame[j];
            end
            r_status       <= n_status;
            r_victim_valid <= (n_count != '0);
            r_victim_frame <= (n_count != '0) ? n_frame[0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_victim_valid = r_victim_valid;
    assign o_victim_frame = r_victim_frame;
    assign o_occupancy    = r_count;

endmodule

### design/fifo_page_replacement_queue_core.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_queue_core
// Load-ordered queue of resident page/frame pairs with victim reporting.
// ----------------------------------------------------------------------------
// Each command word is compared against all resident entries at once in the
// cycle it is accepted, and the queue is then updated in the execute state.
// busy is high during the execute state, and no new word is accepted while
// busy is high. The result appears on the o_ ports with o_strobe high for one
// cycle, the cycle after execute, and must be taken then; it cannot be stalled.
module fifo_page_replacement_queue_core
    import fprq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    input  logic [FRAME_BITS-1:0] i_frame_number,
    output logic                  o_strobe,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_victim_valid,
    output logic [FRAME_BITS-1:0] o_victim_frame,
    output logic [CNT_W-1:0]      o_occupancy
);

    t_dp_cmd cmd;

    fprq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    fprq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_page_number  (i_page_number),
        .i_frame_number (i_frame_number),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_victim_valid (o_victim_valid),
        .o_victim_frame (o_victim_frame),
        .o_occupancy    (o_occupancy)
    );

`ifndef SYNTHESIS
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without execute cycle");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_empty_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_victim_valid != (o_occupancy != '0)) |-> 1'b0)
        else $error("victim valid disagrees with occupancy");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == STS_CLEARED) |-> (o_occupancy == '0))
        else $error("clear left entries");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not enter execute");
`endif

endmodule

### bench/fifo_page_replacement_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_queue_core_tb
// Self-checking bench for the FIFO page replacement queue core.
// A directed opening covers empty-queue commands, duplicate page and frame
// loads, removes that hit and miss at the head and in the middle, clears and
// the unused opcode. Random traffic then runs in fill, balanced and drain
// segments so the queue reaches full and empties again. Words go out in
// bursts with random gaps. Each accepted word is run through a local model
// of the queue and the result is checked field by field when it strobes out.
// ----------------------------------------------------------------------------
module fifo_page_replacement_queue_core_tb;
    import fprq_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        t_func                 func;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        bit                    drain_first;
    } t_page_cmd;

    typedef struct {
        t_status               status;
        logic                  victim_valid;
        logic [FRAME_BITS-1:0] victim_frame;
        logic [CNT_W-1:0]      occupancy;
    } t_page_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [FUNC_W-1:0]     i_func = FN_LOAD;
    logic [PAGE_BITS-1:0]  i_page_number = '0;
    logic [FRAME_BITS-1:0] i_frame_number = '0;
    logic                  o_strobe;
    logic [STAT_W-1:0]     o_status;
    logic                  o_victim_valid;
    logic [FRAME_BITS-1:0] o_victim_frame;
    logic [CNT_W-1:0]      o_occupancy;

    t_page_cmd             cmd_q[$];
    t_page_result          result_q[$];
    logic [PAGE_BITS-1:0]  resident_page[$];
    logic [FRAME_BITS-1:0] resident_frame[$];
    logic [PAGE_BITS-1:0]  pool_page[$];
    logic [FRAME_BITS-1:0] pool_frame[$];

    int bad_words = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    fifo_page_replacement_queue_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_page_number  (i_page_number),
        .i_frame_number (i_frame_number),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_victim_valid (o_victim_valid),
        .o_victim_frame (o_victim_frame),
        .o_occupancy    (o_occupancy)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_page_result apply_page_cmd(t_func fn, logic [PAGE_BITS-1:0] pg,
                                                     logic [FRAME_BITS-1:0] fr);
        t_page_result res;
        int hit;
        hit = -1;
        res.status = STS_DUPLICATE;
        case (fn)
            FN_LOAD: begin
                foreach (resident_page[i])
                    if (resident_page[i] == pg || resident_frame[i] == fr) hit = i;
                if (hit >= 0) begin
                    res.status = STS_DUPLICATE;
                end else if (resident_page.size() >= QUEUE_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    resident_page.insert(resident_page.size(), pg);
                    resident_frame.insert(resident_frame.size(), fr);
                    res.status = STS_INSERTED;
                end
            end
            FN_REMOVE: begin
                for (int i = resident_page.size() - 1; i >= 0; i--)
                    if (resident_page[i] == pg && resident_frame[i] == fr) hit = i;
                if (hit >= 0) begin
                    resident_page.delete(hit);
                    resident_frame.delete(hit);
                    res.status = STS_REMOVED;
                end else begin
                    res.status = STS_NOT_FOUND;
                end
            end
            FN_CLEAR: begin
                resident_page.delete();
                resident_frame.delete();
                res.status = STS_CLEARED;
            end
            default: res.status = STS_DUPLICATE;
        endcase
        res.victim_valid = (resident_page.size() > 0);
        res.victim_frame = res.victim_valid ? resident_frame[0] : '0;
        res.occupancy    = CNT_W'(resident_page.size());
        return res;
    endfunction

    task automatic push_cmd(t_func fn, logic [PAGE_BITS-1:0] pg, logic [FRAME_BITS-1:0] fr,
                            bit drain_first = 1'b0);
        t_page_cmd c;
        c.func = fn;
        c.page = pg;
        c.frame = fr;
        c.drain_first = drain_first;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // random load/remove against the generator's view of what is resident
    task automatic push_random_load();
        int pick;
        int kind;
        logic [PAGE_BITS-1:0]  pg;
        logic [FRAME_BITS-1:0] fr;
        kind = $urandom_range(0, 99);
        pg = PAGE_BITS'($urandom);
        fr = FRAME_BITS'($urandom);
        if (kind < 10 && pool_page.size() > 0) begin
            pick = $urandom_range(0, pool_page.size() - 1);
            pg = pool_page[pick];
        end else if (kind < 20 && pool_page.size() > 0) begin
            pick = $urandom_range(0, pool_page.size() - 1);
            fr = pool_frame[pick];
        end else if (pool_page.size() < QUEUE_DEPTH) begin
            pool_page.insert(pool_page.size(), pg);
            pool_frame.insert(pool_frame.size(), fr);
        end
        push_cmd(FN_LOAD, pg, fr);
    endtask

    task automatic push_random_remove();
        int pick;
        int kind;
        logic [PAGE_BITS-1:0]  pg;
        logic [FRAME_BITS-1:0] fr;
        kind = $urandom_range(0, 99);
        pg = PAGE_BITS'($urandom);
        fr = FRAME_BITS'($urandom);
        if (pool_page.size() > 0 && kind < 85) begin
            pick = $urandom_range(0, pool_page.size() - 1);
            pg = pool_page[pick];
            if (kind < 75) begin
                fr = pool_frame[pick];
                pool_page.delete(pick);
                pool_frame.delete(pick);
            end
        end
        push_cmd(FN_REMOVE, pg, fr);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_page_cmd c;
        bit        fetch;
        bit        start_v;
        if (i_rst_n) begin
            fetch = 1'b0;
            start_v = 1'b0;
            if (start && !busy) begin
                result_q.insert(result_q.size(),
                                apply_page_cmd(t_func'(i_func), i_page_number,
                                               i_frame_number));
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15)
                                                           : $urandom_range(0, 3);
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 12);
                end
                fetch = 1'b1;
            end else if (!start) begin
                fetch = 1'b1;
            end
            if (fetch) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0 &&
                             (!cmd_q[0].drain_first || result_q.size() == 0)) begin
                    c = cmd_q.pop_front();
                    i_func <= c.func;
                    i_page_number <= c.page;
                    i_frame_number <= c.frame;
                    start_v = 1'b1;
                end
                start <= start_v;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (result_q.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("%0t: unexpected word: status %0d valid %b frame %h occ %0d",
                             $realtime, o_status, o_victim_valid, o_victim_frame,
                             o_occupancy);
            end else begin
                want = result_q.pop_front();
                if (o_strobe !== 1'b1 || o_status !== want.status ||
                    o_victim_valid !== want.victim_valid ||
                    o_victim_frame !== want.victim_frame ||
                    o_occupancy !== want.occupancy) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"%0t: mismatch: exp status %0d valid %b frame %h occ %0d,",
                                  " got status %0d valid %b frame %h occ %0d"},
                                 $realtime, want.status, want.victim_valid,
                                 want.victim_frame, want.occupancy, o_status,
                                 o_victim_valid, o_victim_frame, o_occupancy);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int random_words;
        int seg_left;
        int mode;
        int load_pct;
        int remove_pct;
        int r;
        bit first_seg;

        // empty queue corner cases
        push_cmd(FN_REMOVE, 20'h00005, 16'h0005);
        push_cmd(FN_CLEAR,  20'h00000, 16'h0000);
        push_cmd(FN_NONE,   20'hABCDE, 16'h1234);
        // extremes and duplicates
        push_cmd(FN_LOAD,   20'h00000, 16'h0000);
        push_cmd(FN_LOAD,   20'hFFFFF, 16'hFFFF);
        push_cmd(FN_LOAD,   20'hFFFFF, 16'h0001);
        push_cmd(FN_LOAD,   20'h00002, 16'hFFFF);
        push_cmd(FN_LOAD,   20'hFFFFF, 16'hFFFF);
        push_cmd(FN_LOAD,   20'h55555, 16'hAAAA);
        push_cmd(FN_LOAD,   20'hAAAAA, 16'h5555);
        push_cmd(FN_NONE,   20'hFFFFF, 16'hFFFF);
        // partial match, middle remove, head remove
        push_cmd(FN_REMOVE, 20'hFFFFF, 16'h0000);
        push_cmd(FN_REMOVE, 20'hFFFFF, 16'hFFFF, 1'b1);
        push_cmd(FN_REMOVE, 20'h00000, 16'h0000);
        push_cmd(FN_REMOVE, 20'h00000, 16'h0000);
        push_cmd(FN_REMOVE, 20'h55555, 16'hAAAA);
        push_cmd(FN_REMOVE, 20'hAAAAA, 16'h5555);
        push_cmd(FN_LOAD,   20'h12345, 16'h6789);
        push_cmd(FN_CLEAR,  20'hFFFFF, 16'hFFFF);
        push_cmd(FN_LOAD,   20'h12345, 16'h6789);
        push_cmd(FN_REMOVE, 20'h12345, 16'h6789);

        // random segments: fill, balanced, drain
        random_words = 0;
        first_seg = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            mode = first_seg ? 0 : $urandom_range(0, 2);
            seg_left = first_seg ? 120 : $urandom_range(40, 120);
            case (mode)
                0: begin load_pct = 85; remove_pct = 10; end
                1: begin load_pct = 50; remove_pct = 44; end
                default: begin load_pct = 25; remove_pct = 71; end
            endcase
            while (seg_left > 0 && random_words < RANDOM_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < load_pct) begin
                    push_random_load();
                end else if (r < load_pct + remove_pct) begin
                    push_random_remove();
                end else if (r < 98 && mode != 0) begin
                    push_cmd(FN_CLEAR, PAGE_BITS'($urandom), FRAME_BITS'($urandom));
                    pool_page.delete();
                    pool_frame.delete();
                end else begin
                    push_cmd(FN_NONE, PAGE_BITS'($urandom), FRAME_BITS'($urandom));
                    random_words--;
                end
                if ($urandom_range(0, 99) == 0) cmd_q[cmd_q.size() - 1].drain_first = 1'b1;
                random_words++;
                seg_left--;
            end
            first_seg = 1'b0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start || result_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_words == 0 && result_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
design/fprq_pkg.sv
design/fprq_ctrl.sv
design/fprq_datapath.sv
design/fifo_page_replacement_queue_core.sv
bench/fifo_page_replacement_queue_core_tb.sv
